// ===== rtl/vfem_pkg.sv =====
package vfem_pkg;

	localparam int POS_W   = 4;
	localparam int VTYPE_W = 8;
	localparam int FACES   = 6;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// read sequence: the centre voxel first, then one neighbour per face in mask bit order
	localparam logic [2:0] STEP_CENTRE = 3'd0;
	localparam logic [2:0] STEP_LAST   = 3'd6;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/vfem_in_if.sv =====
interface vfem_in_if import vfem_pkg::*;;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic [POS_W-1:0]   pos_z;
	logic [VTYPE_W-1:0] voxel_type;

	modport source (output valid, kind, pos_x, pos_y, pos_z, voxel_type, input ready);
	modport sink   (input valid, kind, pos_x, pos_y, pos_z, voxel_type, output ready);
endinterface

// ===== rtl/vfem_out_if.sv =====
interface vfem_out_if import vfem_pkg::*;;
	logic             valid;
	logic             ready;
	logic [FACES-1:0] face_mask;
	logic             solid;

	modport source (output valid, face_mask, solid, input ready);
	modport sink   (input valid, face_mask, solid, output ready);
endinterface

// ===== rtl/voxel_face_exposure_mask.sv =====
// Voxel face exposure mask over a cubic chunk of EDGE_LEN^3 type codes held in one
// single-port store (x fastest, z slowest). After reset the block sweeps the store to
// empty, one entry a cycle, with item.ready low. A write beat gives no result. A query beat
// occupies the block for seven reads of the store (the voxel and its six neighbours, one per
// cycle through the single port), then a drain state for the last read data and a state that
// posts the result; a query outside the chunk goes straight to posting its result. The result
// sits in an output register, so a new beat is taken while it waits to be collected.
module voxel_face_exposure_mask import vfem_pkg::*; #(
	parameter int EDGE_LEN  = 16,
	parameter int TYPE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	vfem_in_if.sink     item,
	vfem_out_if.source  result
);

	localparam int VOL   = EDGE_LEN * EDGE_LEN * EDGE_LEN;
	localparam int PLANE = EDGE_LEN * EDGE_LEN;
	localparam int AW    = $clog2(VOL);
	localparam int CW    = $clog2(EDGE_LEN);
	localparam logic [AW-1:0] LAST_ADDR = AW'(VOL - 1);
	localparam logic [CW-1:0] LAST_CRD  = CW'(EDGE_LEN - 1);

	logic [TYPE_BITS-1:0] mem [VOL];

	state_t               state_q, state_d;
	logic [AW-1:0]        clr_cnt_q;
	logic [AW-1:0]        addr_q;
	logic [FACES-1:0]     bnd_q;
	logic [2:0]           step_q;
	logic                 vld_s1;
	logic [2:0]           step_s1;
	logic [TYPE_BITS-1:0] rdata_q;
	logic                 solid_q;
	logic [FACES-1:0]     mask_q;
	logic                 res_valid_q;
	logic [FACES-1:0]     res_mask_q;
	logic                 res_solid_q;

	logic                 in_acc;
	logic                 in_chunk;
	logic [CW-1:0]        cx, cy, cz;
	logic [AW-1:0]        in_addr;
	logic [FACES-1:0]     in_bnd;
	logic                 mem_we;
	logic [AW-1:0]        mem_addr;
	logic [TYPE_BITS-1:0] mem_wdata;
	logic [AW-1:0]        stride;
	logic                 stride_neg;
	logic [AW-1:0]        rd_addr;
	logic [2:0]           face_idx;
	logic                 res_free;

	assign in_acc   = item.valid && item.ready;
	assign in_chunk = (int'(item.pos_x) < EDGE_LEN) && (int'(item.pos_y) < EDGE_LEN)
	                  && (int'(item.pos_z) < EDGE_LEN);
	assign cx       = CW'(item.pos_x);
	assign cy       = CW'(item.pos_y);
	assign cz       = CW'(item.pos_z);
	assign in_addr  = AW'(cx) + AW'(cy) * AW'(EDGE_LEN) + AW'(cz) * AW'(PLANE);
	assign in_bnd   = {cz == LAST_CRD, cz == '0, cy == LAST_CRD, cy == '0,
	                   cx == LAST_CRD, cx == '0};
	assign face_idx = step_s1 - 3'd1;
	assign res_free = !res_valid_q || result.ready;

	// shared address unit: centre address plus or minus one axis stride
	always_comb begin
		stride     = '0;
		stride_neg = 1'b0;
		case (step_q)
			3'd1:    begin stride = AW'(1);        stride_neg = 1'b1; end
			3'd2:    begin stride = AW'(1);        stride_neg = 1'b0; end
			3'd3:    begin stride = AW'(EDGE_LEN); stride_neg = 1'b1; end
			3'd4:    begin stride = AW'(EDGE_LEN); stride_neg = 1'b0; end
			3'd5:    begin stride = AW'(PLANE);    stride_neg = 1'b1; end
			3'd6:    begin stride = AW'(PLANE);    stride_neg = 1'b0; end
			default: begin stride = '0;            stride_neg = 1'b0; end
		endcase
		// on a chunk boundary the face is exposed anyway: reread the centre
		if (step_q != STEP_CENTRE && bnd_q[3'(step_q - 3'd1)])
			stride = '0;
		rd_addr = stride_neg ? addr_q - stride : addr_q + stride;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_cnt_q == LAST_ADDR) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc && item.kind == KIND_QUERY)
					state_d = in_chunk ? ST_RUN : ST_DONE;
			end
			ST_RUN:   if (step_q == STEP_LAST) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (res_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = rd_addr;
		mem_wdata  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_cnt_q;
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				mem_we     = item.valid && item.kind == KIND_WRITE && in_chunk;
				mem_addr   = in_addr;
				mem_wdata  = TYPE_BITS'(item.voxel_type);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			step_q      <= STEP_CENTRE;
			vld_s1      <= 1'b0;
			step_s1     <= STEP_CENTRE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + AW'(1);
			if (state_q == ST_RUN)
				step_q <= (step_q == STEP_LAST) ? STEP_CENTRE : step_q + 3'd1;
			vld_s1  <= (state_q == ST_RUN);
			step_s1 <= step_q;
			if (state_q == ST_DONE && res_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			addr_q  <= in_addr;
			bnd_q   <= in_bnd;
			solid_q <= 1'b0;
			mask_q  <= '0;
		end else if (vld_s1) begin
			if (step_s1 == STEP_CENTRE)
				solid_q <= (rdata_q != '0);
			else if (bnd_q[face_idx] || rdata_q == '0)
				mask_q[face_idx] <= 1'b1;
		end
		if (state_q == ST_DONE && res_free) begin
			res_mask_q  <= solid_q ? mask_q : '0;
			res_solid_q <= solid_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.face_mask = res_mask_q;
	assign result.solid     = res_solid_q;

endmodule

// ===== rtl/vfem_checker.sv =====
module vfem_checker import vfem_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_kind,
	input logic             out_valid,
	input logic             out_ready,
	input logic [FACES-1:0] out_face_mask,
	input logic             out_solid
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_face_mask) && $stable(out_solid))
	else $error("result beat changed while stalled");

	// an empty voxel never shows exposed faces
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_solid || out_face_mask == '0)
	else $error("face mask set on an empty voxel");

	// a query keeps the block busy for the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_kind == KIND_QUERY |=> !in_ready)
	else $error("beat taken straight after a query");

	// a write produces no result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_kind == KIND_WRITE && !out_valid |=> !out_valid)
	else $error("result appeared after a write");

endmodule

bind voxel_face_exposure_mask vfem_checker u_vfem_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.in_kind       (item.kind),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_face_mask (result.face_mask),
	.out_solid     (result.solid)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import vfem_pkg::*; ;

	localparam int EDGE   = 16;
	localparam int VOLUME = EDGE * EDGE * EDGE;
	localparam int WIN    = 4;

	typedef struct packed {
		logic [FACES-1:0] face_mask;
		logic             solid;
	} exposure_t;

	logic clk;
	logic arst_n;

	vfem_in_if  item_ch ();
	vfem_out_if result_ch ();

	voxel_face_exposure_mask #(
		.EDGE_LEN  (EDGE),
		.TYPE_BITS (VTYPE_W)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	logic [VTYPE_W-1:0] chunk_model [VOLUME];
	exposure_t          pending_masks [$];
	int                 mismatches = 0;
	bit                 calm = 1'b0;
	int                 hold_len = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12ns * 600000);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int cell_index(input int x, input int y, input int z);
		return x + y * EDGE + z * EDGE * EDGE;
	endfunction

	function automatic bit is_void(input int x, input int y, input int z);
		return chunk_model[cell_index(x, y, z)] == '0;
	endfunction

	function automatic exposure_t predict_exposure(input int x, input int y, input int z);
		exposure_t e;
		e = '0;
		if (is_void(x, y, z))
			return e;
		e.solid        = 1'b1;
		e.face_mask[0] = (x == 0)        || is_void(x - 1, y, z);
		e.face_mask[1] = (x == EDGE - 1) || is_void(x + 1, y, z);
		e.face_mask[2] = (y == 0)        || is_void(x, y - 1, z);
		e.face_mask[3] = (y == EDGE - 1) || is_void(x, y + 1, z);
		e.face_mask[4] = (z == 0)        || is_void(x, y, z - 1);
		e.face_mask[5] = (z == EDGE - 1) || is_void(x, y, z + 1);
		return e;
	endfunction

	// check results first: a result at this edge always belongs to an older query
	always @(posedge clk) begin : beat_monitor
		exposure_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_masks.size() == 0) begin
				$error("result beat with no query outstanding: face_mask %0h solid %0b",
					result_ch.face_mask, result_ch.solid);
				mismatches++;
			end else begin
				want = pending_masks.pop_front();
				if (result_ch.face_mask !== want.face_mask) begin
					$error("face_mask: expected %0h, got %0h", want.face_mask,
						result_ch.face_mask);
					mismatches++;
				end
				if (result_ch.solid !== want.solid) begin
					$error("solid: expected %0b, got %0b", want.solid, result_ch.solid);
					mismatches++;
				end
			end
		end
		if (item_ch.valid && item_ch.ready) begin
			if (item_ch.kind == KIND_WRITE)
				chunk_model[cell_index(int'(item_ch.pos_x), int'(item_ch.pos_y),
					int'(item_ch.pos_z))] = item_ch.voxel_type;
			else
				pending_masks.push_back(predict_exposure(int'(item_ch.pos_x),
					int'(item_ch.pos_y), int'(item_ch.pos_z)));
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_item(input logic kind, input int x, input int y, input int z,
			input int vt);
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= kind;
		item_ch.pos_x      <= x[POS_W-1:0];
		item_ch.pos_y      <= y[POS_W-1:0];
		item_ch.pos_z      <= z[POS_W-1:0];
		item_ch.voxel_type <= vt[VTYPE_W-1:0];
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_masks.size() != 0);
	endtask

	// bias the window towards the chunk faces so the boundary rules get exercised
	function automatic int window_origin();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return EDGE - WIN;
			default: return $urandom_range(0, EDGE - WIN);
		endcase
	endfunction

	task automatic run_cluster(input int n);
		int ox, oy, oz, pick;
		ox = window_origin();
		oy = window_origin();
		oz = window_origin();
		repeat (n) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				send_item(KIND_WRITE, ox + $urandom_range(0, WIN - 1),
					oy + $urandom_range(0, WIN - 1), oz + $urandom_range(0, WIN - 1),
					$urandom_range(1, 255));
			else if (pick < 5)
				send_item(KIND_WRITE, ox + $urandom_range(0, WIN - 1),
					oy + $urandom_range(0, WIN - 1), oz + $urandom_range(0, WIN - 1), 0);
			else
				send_item(KIND_QUERY, ox + $urandom_range(0, WIN - 1),
					oy + $urandom_range(0, WIN - 1), oz + $urandom_range(0, WIN - 1),
					$urandom_range(0, 255));
		end
	endtask

	task automatic test_corners();
		send_item(KIND_QUERY, 0, 0, 0, 0);
		send_item(KIND_WRITE, 0, 0, 0, 255);
		send_item(KIND_QUERY, 0, 0, 0, 0);
		send_item(KIND_WRITE, EDGE - 1, EDGE - 1, EDGE - 1, 1);
		send_item(KIND_QUERY, EDGE - 1, EDGE - 1, EDGE - 1, 255);
		send_item(KIND_WRITE, 1, 0, 0, 8'h80);
		send_item(KIND_QUERY, 0, 0, 0, 0);
	endtask

	task automatic test_enclosed();
		send_item(KIND_WRITE, 7, 7, 7, 8'hAA);
		send_item(KIND_WRITE, 6, 7, 7, 8'h55);
		send_item(KIND_WRITE, 8, 7, 7, 8'h55);
		send_item(KIND_WRITE, 7, 6, 7, 8'h55);
		send_item(KIND_WRITE, 7, 8, 7, 8'h55);
		send_item(KIND_WRITE, 7, 7, 6, 8'h55);
		send_item(KIND_WRITE, 7, 7, 8, 8'h55);
		send_item(KIND_QUERY, 7, 7, 7, 0);
		// clear one neighbour, then query the centre and the hole itself
		send_item(KIND_WRITE, 8, 7, 7, 0);
		send_item(KIND_QUERY, 7, 7, 7, 0);
		send_item(KIND_QUERY, 8, 7, 7, 0);
	endtask

	task automatic test_clusters();
		repeat (28) run_cluster(30);
	endtask

	task automatic test_noise();
		repeat (300)
			send_item(1'($urandom_range(0, 1)), $urandom_range(0, EDGE - 1),
				$urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
				$urandom_range(0, 255));
	endtask

	// hold the result side so the output register fills and the input stalls
	task automatic test_backpressure();
		hold_len = 300;
		repeat (30)
			send_item(KIND_QUERY, $urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
				$urandom_range(0, EDGE - 1), $urandom_range(0, 255));
		wait_drained();
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			run_cluster(20);
			wait_drained();
		end
	endtask

	task automatic test_steady();
		calm = 1'b1;
		repeat (6) run_cluster(25);
	endtask

	initial begin
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.kind       <= KIND_WRITE;
		item_ch.pos_x      <= '0;
		item_ch.pos_y      <= '0;
		item_ch.pos_z      <= '0;
		item_ch.voxel_type <= '0;
		foreach (chunk_model[i])
			chunk_model[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_corners();
		test_enclosed();
		test_clusters();
		test_noise();
		test_backpressure();
		test_drain_pause();
		test_steady();

		wait_drained();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
